// ===== rtl/core/cte_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and beat types of the card table engine
package cte_pkg;

  localparam int NUM_CARDS   = 4096;
  localparam int CARD_BYTES  = 512;
  localparam int CARD_W      = $clog2(NUM_CARDS);
  localparam int CNT_W       = $clog2(NUM_CARDS + 1);
  localparam int CARD_SHIFT  = $clog2(CARD_BYTES);
  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 22;
  localparam int THR_W       = 16;
  localparam int DCNT_W      = 16;
  localparam int STATE_W     = 2;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = CFG_ADDR_W - REG_SEL_LSB;

  localparam int HEAP_SIZE_RST  = 2097152;
  localparam int HOT_THR_RST    = 8;
  localparam int CARDS_RST_RAW  = (HEAP_SIZE_RST + CARD_BYTES - 1) / CARD_BYTES;
  localparam int CARD_COUNT_RST = (CARDS_RST_RAW > NUM_CARDS) ? NUM_CARDS : CARDS_RST_RAW;

  // commands
  localparam logic [CMD_W-1:0] CMD_RECORD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_YOUNG = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_CARD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SCAN       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_COUNT      = 3'd6;

  // card states
  localparam logic [STATE_W-1:0] CS_CLEAN = 2'd0;
  localparam logic [STATE_W-1:0] CS_DIRTY = 2'd1;
  localparam logic [STATE_W-1:0] CS_YOUNG = 2'd2;
  localparam logic [STATE_W-1:0] CS_HOT   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_DIRTY = 2'd2;

  // register indexes
  localparam logic [REG_SEL_W-1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_HEAP_SIZE   = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_HOT_THR     = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_PROMOTE_EN  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [CARD_W-1:0] card_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CARD_W-1:0]   result_card;
    logic [STATE_W-1:0]  card_state;
    logic                is_dirty;
    logic                is_hot;
    logic                promote_slot;
    logic [ADDR_W-1:0]   range_start;
    logic [ADDR_W-1:0]   range_end;
    logic [TOTAL_W-1:0]  dirty_total;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [SIZE_W-1:0] heap_size;
    logic [THR_W-1:0]  hot_threshold;
    logic              promote_enable;
    logic [CNT_W-1:0]  card_count;
  } cfg_t;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic rd_card;
    logic apply;
    logic sweep_start;
    logic sweep_step;
    logic sweep_init;
    logic walk_start;
    logic walk_step;
    logic take_hit;
    logic finish_walk;
    logic range_lo;
    logic range_hi;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             hit;
    logic             walk_done;
    logic             sweep_last;
    logic             out_free;
  } dp_stat_t;

  function automatic logic is_dirty_state(input logic [STATE_W-1:0] s);
    return (s == CS_DIRTY) || (s == CS_HOT);
  endfunction

endpackage

// ===== rtl/core/gc_card_table_engine.sv =====
`timescale 1ns / 1ps
// Card table engine for a generational collector's write barrier. The covered
// heap is split into 512-byte cards, 4096 of them, each holding a two-bit state
// and a saturating 16-bit dirtying count in two card memories with one read
// and one write port each. One command is taken at a time and answers with
// exactly one result beat.
// After reset the block runs a clearing pass over both memories and takes no
// command until it ends; configuration writes are taken at any time. Record
// store, mark young, query and clear card each pass through decode, memory
// read, update and output load, skipping the read and update when the card
// lies outside the covered heap; the unused code goes from decode straight to
// output load. Clear all sweeps all 4096 cards, one card a cycle. Count dirty
// and scan next walk the state memory one card a cycle through its single read
// port. A finished result waits in an output register, and the next command is
// accepted while it does.
module gc_card_table_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cte_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cte_pkg::out_item_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cte_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cte_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cte_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  cte_pkg::cfg_t     cfg;
  cte_pkg::dp_cmd_t  dp_cmd;
  cte_pkg::dp_stat_t dp_stat;

  cte_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  cte_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (dp_stat),
    .dp      (dp_cmd)
  );

  cte_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/cte_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module cte_ram #(
  parameter int WIDTH = cte_pkg::STATE_W,
  parameter int DEPTH = cte_pkg::NUM_CARDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cte_regs.sv =====
`timescale 1ns / 1ps
// configuration register file behind the apb-style port
module cte_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cte_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cte_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cte_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output cte_pkg::cfg_t                    cfg
);

  localparam int RAW_W = cte_pkg::SIZE_W + 1 - cte_pkg::CARD_SHIFT;

  logic [cte_pkg::ADDR_W-1:0] heap_base_r, heap_base_nxt;
  logic [cte_pkg::SIZE_W-1:0] heap_size_r, heap_size_nxt;
  logic [cte_pkg::THR_W-1:0]  hot_thr_r, hot_thr_nxt;
  logic                       promote_en_r, promote_en_nxt;
  logic [cte_pkg::CNT_W-1:0]  card_count_r, card_count_nxt;

  logic                          wr_en;
  logic [cte_pkg::REG_SEL_W-1:0] reg_sel;
  logic [cte_pkg::SIZE_W-1:0]    size_in;
  logic [cte_pkg::SIZE_W:0]      size_up;
  logic [RAW_W-1:0]              cards_raw;
  logic [cte_pkg::CNT_W-1:0]     cards_cap;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[cte_pkg::CFG_ADDR_W-1:cte_pkg::REG_SEL_LSB];

  // card count is ceiling of size over card bytes, capped at the table depth
  assign size_in   = pwdata[cte_pkg::SIZE_W-1:0];
  assign size_up   = {1'b0, size_in} + (cte_pkg::SIZE_W + 1)'(cte_pkg::CARD_BYTES - 1);
  assign cards_raw = size_up[cte_pkg::SIZE_W:cte_pkg::CARD_SHIFT];
  assign cards_cap = (cards_raw > RAW_W'(cte_pkg::NUM_CARDS)) ?
                     cte_pkg::CNT_W'(cte_pkg::NUM_CARDS) : cte_pkg::CNT_W'(cards_raw);

  always_comb begin
    heap_base_nxt  = heap_base_r;
    heap_size_nxt  = heap_size_r;
    hot_thr_nxt    = hot_thr_r;
    promote_en_nxt = promote_en_r;
    card_count_nxt = card_count_r;
    if (wr_en) begin
      case (reg_sel)
        cte_pkg::REG_HEAP_BASE: heap_base_nxt = pwdata[cte_pkg::ADDR_W-1:0];
        cte_pkg::REG_HEAP_SIZE: begin
          heap_size_nxt  = size_in;
          card_count_nxt = cards_cap;
        end
        cte_pkg::REG_HOT_THR:    hot_thr_nxt    = pwdata[cte_pkg::THR_W-1:0];
        cte_pkg::REG_PROMOTE_EN: promote_en_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_size_r  <= cte_pkg::SIZE_W'(cte_pkg::HEAP_SIZE_RST);
      hot_thr_r    <= cte_pkg::THR_W'(cte_pkg::HOT_THR_RST);
      promote_en_r <= 1'b1;
      card_count_r <= cte_pkg::CNT_W'(cte_pkg::CARD_COUNT_RST);
    end else begin
      heap_base_r  <= heap_base_nxt;
      heap_size_r  <= heap_size_nxt;
      hot_thr_r    <= hot_thr_nxt;
      promote_en_r <= promote_en_nxt;
      card_count_r <= card_count_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      cte_pkg::REG_HEAP_BASE:  prdata = cte_pkg::CFG_DATA_W'(heap_base_r);
      cte_pkg::REG_HEAP_SIZE:  prdata = cte_pkg::CFG_DATA_W'(heap_size_r);
      cte_pkg::REG_HOT_THR:    prdata = cte_pkg::CFG_DATA_W'(hot_thr_r);
      cte_pkg::REG_PROMOTE_EN: prdata = cte_pkg::CFG_DATA_W'(promote_en_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.heap_base      = heap_base_r;
  assign cfg.heap_size      = heap_size_r;
  assign cfg.hot_threshold  = hot_thr_r;
  assign cfg.promote_enable = promote_en_r;
  assign cfg.card_count     = card_count_r;

endmodule

// ===== rtl/core/cte_ctrl.sv =====
`timescale 1ns / 1ps
// command sequencer of the card table engine
module cte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cte_pkg::dp_stat_t stat,
  output cte_pkg::dp_cmd_t  dp
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_APPLY,
    S_SWEEP,
    S_WALK,
    S_RANGE_LO,
    S_RANGE_HI,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    dp        = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        // clearing pass over both card memories after reset
        dp.sweep_step = 1'b1;
        dp.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp.latch_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        dp.decode = 1'b1;
        case (stat.cmd)
          cte_pkg::CMD_RECORD, cte_pkg::CMD_MARK_YOUNG,
          cte_pkg::CMD_QUERY, cte_pkg::CMD_CLEAR_CARD: state_nxt = S_READ;
          cte_pkg::CMD_CLEAR_ALL: begin
            dp.sweep_start = 1'b1;
            state_nxt      = S_SWEEP;
          end
          cte_pkg::CMD_SCAN, cte_pkg::CMD_COUNT: begin
            dp.walk_start = 1'b1;
            state_nxt     = S_WALK;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_READ: begin
        if (stat.in_range) begin
          dp.rd_card = 1'b1;
          state_nxt  = S_APPLY;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_APPLY: begin
        dp.apply  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SWEEP: begin
        dp.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_RESP;
        end
      end
      S_WALK: begin
        if ((stat.cmd == cte_pkg::CMD_SCAN) && stat.hit) begin
          dp.take_hit = 1'b1;
          state_nxt   = S_RANGE_LO;
        end else if (stat.walk_done) begin
          dp.finish_walk = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          dp.walk_step = 1'b1;
        end
      end
      S_RANGE_LO: begin
        dp.range_lo = 1'b1;
        state_nxt   = S_RANGE_HI;
      end
      S_RANGE_HI: begin
        dp.range_hi = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          dp.load_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/cte_datapath.sv =====
`timescale 1ns / 1ps
// card memories, walk pointers, result assembly and output register
module cte_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  cte_pkg::in_item_t  in_data,
  input  cte_pkg::cfg_t      cfg,
  input  cte_pkg::dp_cmd_t   cmd,
  output cte_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output cte_pkg::out_item_t out_data
);

  localparam int OFF_CARD_W = cte_pkg::ADDR_W - cte_pkg::CARD_SHIFT;

  // latched input beat
  logic [cte_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [cte_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [cte_pkg::CARD_W-1:0] cidx_r, cidx_nxt;

  logic [cte_pkg::CARD_W-1:0] card_r, card_nxt;
  logic                       in_range_r, in_range_nxt;
  logic [cte_pkg::CARD_W-1:0] ptr_r, ptr_nxt;
  logic [cte_pkg::CARD_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                       pend_r, pend_nxt;
  logic [cte_pkg::CNT_W-1:0]  issue_r, issue_nxt;
  logic [cte_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [cte_pkg::CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [cte_pkg::ADDR_W-1:0] endoff_r, endoff_nxt;
  cte_pkg::out_item_t         res_r, res_nxt;
  cte_pkg::out_item_t         out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // memory ports
  logic                        st_we, cn_we;
  logic [cte_pkg::CARD_W-1:0]  st_waddr, cn_waddr, raddr;
  logic [cte_pkg::STATE_W-1:0] st_wdata, st_rdata;
  logic [cte_pkg::DCNT_W-1:0]  cn_wdata, cn_rdata;

  // decode
  logic [cte_pkg::ADDR_W-1:0] addr_off;
  logic                       addr_below;
  logic [OFF_CARD_W-1:0]      addr_card;
  logic                       addr_in;
  logic                       idx_in;

  // read-modify-write of one card
  logic                        cur_dirty;
  logic [cte_pkg::STATE_W-1:0] new_st;
  logic [cte_pkg::DCNT_W-1:0]  new_cnt;
  logic                        st_wr, cn_wr;
  logic                        new_hot;

  // walk
  logic [cte_pkg::CNT_W-1:0]  ptr_inc;
  logic [cte_pkg::CARD_W-1:0] ptr_wrap;
  logic [cte_pkg::CARD_W-1:0] scan_start;
  logic [cte_pkg::ADDR_W-1:0] end_full;
  logic [cte_pkg::ADDR_W-1:0] size_ext;

  assign addr_off   = addr_r - cfg.heap_base;
  assign addr_below = addr_r < cfg.heap_base;
  assign addr_card  = addr_off[cte_pkg::ADDR_W-1:cte_pkg::CARD_SHIFT];
  assign addr_in    = !addr_below && (addr_card < OFF_CARD_W'(cfg.card_count));
  assign idx_in     = cte_pkg::CNT_W'(cidx_r) < cfg.card_count;

  always_comb begin
    cur_dirty = cte_pkg::is_dirty_state(st_rdata);
    new_st    = st_rdata;
    new_cnt   = cn_rdata;
    st_wr     = 1'b0;
    cn_wr     = 1'b0;
    case (cmd_r)
      cte_pkg::CMD_RECORD: begin
        if (!cur_dirty) begin
          new_st  = cte_pkg::CS_DIRTY;
          new_cnt = (cn_rdata == '1) ? cn_rdata : cn_rdata + 1'b1;
          st_wr   = 1'b1;
          cn_wr   = 1'b1;
        end
      end
      cte_pkg::CMD_MARK_YOUNG: begin
        new_st = cte_pkg::CS_YOUNG;
        st_wr  = 1'b1;
      end
      cte_pkg::CMD_CLEAR_CARD: begin
        new_st = cte_pkg::CS_CLEAN;
        st_wr  = 1'b1;
      end
      default: ;
    endcase
    new_hot = new_cnt > cfg.hot_threshold;
  end

  // scan starts at the cursor, or at card zero once the cursor is past the end
  assign scan_start = ((cmd_r == cte_pkg::CMD_SCAN) && (cursor_r < cfg.card_count)) ?
                      cursor_r[cte_pkg::CARD_W-1:0] : '0;
  assign ptr_inc    = cte_pkg::CNT_W'(ptr_r) + 1'b1;
  assign ptr_wrap   = (ptr_inc == cfg.card_count) ? '0 : ptr_inc[cte_pkg::CARD_W-1:0];
  assign end_full   = (cte_pkg::ADDR_W'(card_r) + 1'b1) << cte_pkg::CARD_SHIFT;
  assign size_ext   = cte_pkg::ADDR_W'(cfg.heap_size);

  always_comb begin
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    cidx_nxt      = cidx_r;
    card_nxt      = card_r;
    in_range_nxt  = in_range_r;
    ptr_nxt       = ptr_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = pend_r;
    issue_nxt     = issue_r;
    total_nxt     = total_r;
    cursor_nxt    = cursor_r;
    endoff_nxt    = endoff_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.latch_in) begin
      cmd_nxt  = in_data.command;
      addr_nxt = in_data.address;
      cidx_nxt = in_data.card_index;
    end

    if (cmd.decode) begin
      res_nxt      = '0;
      in_range_nxt = 1'b0;
      case (cmd_r)
        cte_pkg::CMD_RECORD, cte_pkg::CMD_MARK_YOUNG: begin
          card_nxt     = addr_card[cte_pkg::CARD_W-1:0];
          in_range_nxt = addr_in;
          if (!addr_in) begin
            res_nxt.status = cte_pkg::STATUS_OUTSIDE;
            if (!addr_below) begin
              res_nxt.result_card = addr_card[cte_pkg::CARD_W-1:0];
            end
          end
        end
        cte_pkg::CMD_QUERY, cte_pkg::CMD_CLEAR_CARD: begin
          card_nxt     = cidx_r;
          in_range_nxt = idx_in;
          if (!idx_in) begin
            res_nxt.status      = cte_pkg::STATUS_OUTSIDE;
            res_nxt.result_card = cidx_r;
          end
        end
        default: ;
      endcase
    end

    if (cmd.apply) begin
      res_nxt.result_card  = card_r;
      res_nxt.card_state   = new_st;
      res_nxt.is_dirty     = cte_pkg::is_dirty_state(new_st);
      res_nxt.is_hot       = new_hot;
      res_nxt.promote_slot = (cmd_r == cte_pkg::CMD_RECORD) && cfg.promote_enable && new_hot;
    end

    if (cmd.sweep_start) begin
      ptr_nxt = '0;
    end
    if (cmd.sweep_step) begin
      ptr_nxt = ptr_r + 1'b1;
    end

    if (cmd.walk_start) begin
      ptr_nxt   = scan_start;
      issue_nxt = '0;
      pend_nxt  = 1'b0;
      total_nxt = '0;
    end

    // one read issued per cycle, checked in the next cycle
    if (cmd.walk_step) begin
      if (issue_r < cfg.card_count) begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = ptr_r;
        issue_nxt    = issue_r + 1'b1;
        ptr_nxt      = ptr_wrap;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && cur_dirty) begin
        total_nxt = total_r + 1'b1;
      end
    end

    if (cmd.take_hit) begin
      res_nxt.result_card = pend_idx_r;
      res_nxt.card_state  = cte_pkg::CS_CLEAN;
      res_nxt.is_dirty    = 1'b0;
      res_nxt.is_hot      = cn_rdata > cfg.hot_threshold;
      card_nxt            = pend_idx_r;
      cursor_nxt          = cte_pkg::CNT_W'(pend_idx_r) + 1'b1;
      pend_nxt            = 1'b0;
    end

    if (cmd.finish_walk) begin
      if (cmd_r == cte_pkg::CMD_SCAN) begin
        res_nxt.status = cte_pkg::STATUS_NO_DIRTY;
        cursor_nxt     = '0;
      end else begin
        res_nxt.dirty_total = cte_pkg::TOTAL_W'(total_r);
      end
    end

    if (cmd.range_lo) begin
      res_nxt.range_start = cfg.heap_base +
                            (cte_pkg::ADDR_W'(card_r) << cte_pkg::CARD_SHIFT);
      endoff_nxt          = (end_full > size_ext) ? size_ext : end_full;
    end
    if (cmd.range_hi) begin
      res_nxt.range_end = cfg.heap_base + endoff_r;
    end

    if (cmd.load_out) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      issue_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      issue_r     <= issue_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    cidx_r     <= cidx_nxt;
    card_r     <= card_nxt;
    in_range_r <= in_range_nxt;
    pend_idx_r <= pend_idx_nxt;
    total_r    <= total_nxt;
    endoff_r   <= endoff_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // memory port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = card_r;
    st_wdata = new_st;
    if (cmd.sweep_step) begin
      st_we    = 1'b1;
      st_waddr = ptr_r;
      st_wdata = cte_pkg::CS_CLEAN;
    end else if (cmd.apply) begin
      st_we = st_wr;
    end else if (cmd.take_hit) begin
      st_we    = 1'b1;
      st_waddr = pend_idx_r;
      st_wdata = cte_pkg::CS_CLEAN;
    end

    cn_we    = 1'b0;
    cn_waddr = card_r;
    cn_wdata = new_cnt;
    if (cmd.sweep_step && cmd.sweep_init) begin
      cn_we    = 1'b1;
      cn_waddr = ptr_r;
      cn_wdata = '0;
    end else if (cmd.apply) begin
      cn_we = cn_wr;
    end
  end

  assign raddr = cmd.rd_card ? card_r : ptr_r;

  cte_ram #(
    .WIDTH(cte_pkg::STATE_W),
    .DEPTH(cte_pkg::NUM_CARDS)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(raddr),
    .rdata(st_rdata)
  );

  cte_ram #(
    .WIDTH(cte_pkg::DCNT_W),
    .DEPTH(cte_pkg::NUM_CARDS)
  ) u_count_ram (
    .clk  (clk),
    .we   (cn_we),
    .waddr(cn_waddr),
    .wdata(cn_wdata),
    .raddr(raddr),
    .rdata(cn_rdata)
  );

  assign stat.cmd        = cmd_r;
  assign stat.in_range   = in_range_r;
  assign stat.hit        = pend_r && cur_dirty;
  assign stat.walk_done  = (issue_r == cfg.card_count) && !pend_r;
  assign stat.sweep_last = ptr_r == cte_pkg::CARD_W'(cte_pkg::NUM_CARDS - 1);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/gc_card_table_engine_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the card table engine: own card table predictor, random traffic
module gc_card_table_engine_test;
  import cte_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int WATCH_LIMIT   = 20000;
  localparam int LONG_HOLD     = 600;
  localparam int BACKLOG_DEPTH = 32;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gc_card_table_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted card table and register copy
  logic [STATE_W-1:0] card_st [NUM_CARDS];
  logic [DCNT_W-1:0]  dirt_cnt [NUM_CARDS];
  logic [TOTAL_W-1:0] scan_pos = '0;
  logic [ADDR_W-1:0]  cfg_base = '0;
  logic [SIZE_W-1:0]  cfg_size = SIZE_W'(HEAP_SIZE_RST);
  logic [THR_W-1:0]   cfg_thr = THR_W'(HOT_THR_RST);
  logic               cfg_promote = 1'b1;

  in_item_t  cmd_backlog [$];
  out_item_t due_results [$];

  int cmds_taken = 0;
  int results_seen = 0;
  int faults = 0;
  int settings_used = 0;
  int hold_at = 32'h7fffffff;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  bit send_idling = 1'b1;
  bit take_idling = 1'b1;
  int quiet_cycles = 0;

  function automatic int unsigned live_cards();
    int unsigned c;
    c = (int'(cfg_size) + CARD_BYTES - 1) / CARD_BYTES;
    return (c > NUM_CARDS) ? NUM_CARDS : c;
  endfunction

  function automatic logic refs_pending(input logic [STATE_W-1:0] s);
    return (s == CS_DIRTY) || (s == CS_HOT);
  endfunction

  function automatic logic card_hot(input int unsigned k);
    return dirt_cnt[k] > cfg_thr;
  endfunction

  function automatic out_item_t card_report(input int unsigned k);
    out_item_t r;
    r = '0;
    r.status      = STATUS_DONE;
    r.result_card = CARD_W'(k);
    r.card_state  = card_st[k];
    r.is_dirty    = refs_pending(card_st[k]);
    r.is_hot      = card_hot(k);
    return r;
  endfunction

  // applies one command to the predicted table and returns the beat it should produce
  function automatic out_item_t card_table_step(input in_item_t cmd);
    out_item_t         r;
    int unsigned       n, k, start, hit, tot, end_off;
    logic [ADDR_W-1:0] span;
    logic              found;
    r = '0;
    n = live_cards();
    k = 0;
    tot = 0;
    found = 1'b0;
    case (cmd.command)
      CMD_RECORD, CMD_MARK_YOUNG: begin
        if (cmd.address < cfg_base) begin
          r.status = STATUS_OUTSIDE;
        end else begin
          span = (cmd.address - cfg_base) >> CARD_SHIFT;
          if (span >= n) begin
            r.status      = STATUS_OUTSIDE;
            r.result_card = span[CARD_W-1:0];
          end else begin
            k = 32'(span[CARD_W-1:0]);
            if (cmd.command == CMD_MARK_YOUNG) begin
              card_st[k] = CS_YOUNG;
            end else if (!refs_pending(card_st[k])) begin
              card_st[k] = CS_DIRTY;
              if (dirt_cnt[k] != '1) dirt_cnt[k] = dirt_cnt[k] + 1'b1;
            end
            r = card_report(k);
            if (cmd.command == CMD_RECORD) r.promote_slot = cfg_promote && card_hot(k);
          end
        end
      end
      CMD_QUERY, CMD_CLEAR_CARD: begin
        if (cmd.card_index >= n) begin
          r.status      = STATUS_OUTSIDE;
          r.result_card = cmd.card_index;
        end else begin
          if (cmd.command == CMD_CLEAR_CARD) card_st[cmd.card_index] = CS_CLEAN;
          r = card_report(cmd.card_index);
        end
      end
      CMD_CLEAR_ALL: begin
        foreach (card_st[j]) card_st[j] = CS_CLEAN;
      end
      CMD_SCAN: begin
        start = (scan_pos < n) ? scan_pos : 0;
        for (int unsigned t = 0; t < n && !found; t++) begin
          hit = (start + t >= n) ? start + t - n : start + t;
          if (refs_pending(card_st[hit])) begin
            found = 1'b1;
            k = hit;
          end
        end
        if (!found) begin
          r.status = STATUS_NO_DIRTY;
          scan_pos = '0;
        end else begin
          card_st[k] = CS_CLEAN;
          r = card_report(k);
          end_off = (k + 1) * CARD_BYTES;
          if (end_off > cfg_size) end_off = cfg_size;
          r.range_start = cfg_base + ADDR_W'(k * CARD_BYTES);
          r.range_end   = cfg_base + ADDR_W'(end_off);
          scan_pos = TOTAL_W'(k + 1);
        end
      end
      CMD_COUNT: begin
        for (int unsigned t = 0; t < n; t++)
          if (refs_pending(card_st[t])) tot++;
        r.dirty_total = TOTAL_W'(tot);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic cmp_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      faults++;
      if (faults <= 10)
        $display("mismatch on %s (result %0d): expected %0h, got %0h",
                 what, results_seen, want, got);
    end
  endtask

  task automatic check_result(input out_item_t want, input out_item_t got);
    cmp_field("status", want.status, got.status);
    cmp_field("result_card", want.result_card, got.result_card);
    cmp_field("card_state", want.card_state, got.card_state);
    cmp_field("is_dirty", want.is_dirty, got.is_dirty);
    cmp_field("is_hot", want.is_hot, got.is_hot);
    cmp_field("promote_slot", want.promote_slot, got.promote_slot);
    cmp_field("range_start", want.range_start, got.range_start);
    cmp_field("range_end", want.range_end, got.range_end);
    cmp_field("dirty_total", want.dirty_total, got.dirty_total);
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(card_table_step(in_data));
        cmds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && send_idling && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 14);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          faults++;
          if (faults <= 10) $display("result beat %0d arrived with nothing outstanding",
                                     results_seen);
        end else begin
          check_result(due_results.pop_front(), out_data);
        end
      end
      // one long back-pressure stretch so the engine fills and stalls its input
      if (!hold_done && cmds_taken >= hold_at) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (take_gap == 0 && take_idling && $urandom_range(0, 9) == 0)
          take_gap = $urandom_range(1, 14);
        if (take_gap != 0) begin
          take_gap--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, due_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic offer(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                       input logic [CARD_W-1:0] ci);
    in_item_t it;
    while (cmd_backlog.size() >= BACKLOG_DEPTH) @(negedge clk);
    it.command    = c;
    it.address    = a;
    it.card_index = ci;
    cmd_backlog.push_back(it);
  endtask

  task automatic settle();
    do @(negedge clk); while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_SEL_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] held;
    held = '0;
    case (sel)
      REG_HEAP_BASE: begin
        cfg_base = value[ADDR_W-1:0];
        held = CFG_DATA_W'(cfg_base);
      end
      REG_HEAP_SIZE: begin
        cfg_size = value[SIZE_W-1:0];
        held = CFG_DATA_W'(cfg_size);
      end
      REG_HOT_THR: begin
        cfg_thr = value[THR_W-1:0];
        held = CFG_DATA_W'(cfg_thr);
      end
      REG_PROMOTE_EN: begin
        cfg_promote = value[0];
        held = CFG_DATA_W'(cfg_promote);
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(sel) << REG_SEL_LSB;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read the register straight back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cmp_field("register readback", held, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [THR_W-1:0] thr, input logic prom);
    settle();
    reg_write(REG_HEAP_BASE, CFG_DATA_W'(base));
    reg_write(REG_HEAP_SIZE, CFG_DATA_W'(size));
    reg_write(REG_HOT_THR, CFG_DATA_W'(thr));
    reg_write(REG_PROMOTE_EN, CFG_DATA_W'(prom));
    settings_used++;
  endtask

  // mostly writes into a few busy cards so counts climb past the threshold
  function automatic in_item_t random_cmd(input int unsigned slow_pm);
    in_item_t    it;
    int unsigned n, roll, pick;
    n = live_cards();
    it.address    = ADDR_W'({$urandom, $urandom});
    it.card_index = CARD_W'($urandom);
    roll = $urandom_range(0, 999);
    if (roll < slow_pm) it.command = CMD_SCAN;
    else if (roll < 2 * slow_pm) it.command = CMD_COUNT;
    else if (roll < 2 * slow_pm + 4) it.command = CMD_CLEAR_ALL;
    else if (roll < 2 * slow_pm + 20) it.command = CMD_UNUSED;
    else begin
      roll = $urandom_range(0, 99);
      it.command = (roll < 45) ? CMD_RECORD : (roll < 62) ? CMD_MARK_YOUNG :
                   (roll < 82) ? CMD_QUERY : CMD_CLEAR_CARD;
    end
    if (n != 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 1) == 1)
        pick = ($urandom_range(0, 9) == 0) ? n - 1 : $urandom_range(0, (n < 8 ? n : 8) - 1);
      else
        pick = $urandom_range(0, n - 1);
      it.card_index = CARD_W'(pick);
      it.address    = cfg_base + ADDR_W'(pick * CARD_BYTES)
                      + ADDR_W'($urandom_range(0, CARD_BYTES - 1));
    end else if ($urandom_range(0, 1) == 1) begin
      // just past the covered heap
      it.address    = cfg_base + ADDR_W'(n * CARD_BYTES) + ADDR_W'($urandom_range(0, 2047));
      it.card_index = CARD_W'(n + $urandom_range(0, 3));
    end
    return it;
  endfunction

  initial begin
    in_item_t    it;
    int unsigned p, i, slow;
    foreach (card_st[j]) begin
      card_st[j]  = CS_CLEAN;
      dirt_cnt[j] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full 2 MiB heap at address zero
    offer(CMD_RECORD, 48'h0, CARD_W'($urandom));
    offer(CMD_RECORD, 48'h1FF, CARD_W'($urandom));
    offer(CMD_RECORD, 48'h1F_FFFF, CARD_W'($urandom));
    offer(CMD_RECORD, 48'h20_0000, CARD_W'($urandom));
    offer(CMD_MARK_YOUNG, 48'hFFFF_FFFF_FFFF, CARD_W'($urandom));
    offer(CMD_MARK_YOUNG, 48'h200, CARD_W'($urandom));
    offer(CMD_RECORD, 48'h3FF, CARD_W'($urandom));
    offer(CMD_QUERY, ADDR_W'($urandom), 12'h000);
    offer(CMD_QUERY, ADDR_W'($urandom), 12'hFFF);
    offer(CMD_CLEAR_CARD, ADDR_W'($urandom), 12'h001);
    offer(CMD_COUNT, ADDR_W'($urandom), CARD_W'($urandom));
    repeat (4) offer(CMD_SCAN, ADDR_W'($urandom), CARD_W'($urandom));
    offer(CMD_RECORD, 48'h400, CARD_W'($urandom));
    offer(CMD_CLEAR_ALL, ADDR_W'($urandom), CARD_W'($urandom));
    offer(CMD_QUERY, ADDR_W'($urandom), 12'h002);
    offer(CMD_UNUSED, ADDR_W'({$urandom, $urandom}), CARD_W'($urandom));

    // heap at the top of the address space: range end wraps, partial last card
    set_config(48'hFFFF_FFFF_FF00, 22'd1000, 16'd0, 1'b1);
    offer(CMD_RECORD, 48'h0, CARD_W'($urandom));
    offer(CMD_RECORD, 48'hFFFF_FFFF_FF80, CARD_W'($urandom));
    offer(CMD_RECORD, 48'hFFFF_FFFF_FFFF, CARD_W'($urandom));
    offer(CMD_SCAN, ADDR_W'($urandom), CARD_W'($urandom));
    offer(CMD_QUERY, ADDR_W'($urandom), 12'd1);
    offer(CMD_QUERY, ADDR_W'($urandom), 12'd2);

    set_config(48'h1000, 22'd1000, 16'hFFFF, 1'b0);
    offer(CMD_RECORD, 48'h1258, CARD_W'($urandom));
    offer(CMD_SCAN, ADDR_W'($urandom), CARD_W'($urandom));
    offer(CMD_COUNT, ADDR_W'($urandom), CARD_W'($urandom));

    // empty heap
    set_config(48'h0, 22'd0, 16'd1, 1'b0);
    offer(CMD_RECORD, 48'h0, CARD_W'($urandom));
    offer(CMD_QUERY, ADDR_W'($urandom), 12'd0);
    offer(CMD_SCAN, ADDR_W'($urandom), CARD_W'($urandom));
    offer(CMD_COUNT, ADDR_W'($urandom), CARD_W'($urandom));

    // a few clean-to-dirty turns on card 0 push it past a low threshold
    set_config(48'h0, 22'd2048, 16'd2, 1'b1);
    send_idling = 1'b0;
    take_idling = 1'b0;
    for (i = 0; i < 6; i++) begin
      offer(CMD_RECORD, ADDR_W'($urandom_range(0, CARD_BYTES - 1)), CARD_W'($urandom));
      offer(CMD_CLEAR_CARD, ADDR_W'($urandom), 12'd0);
    end
    offer(CMD_RECORD, 48'h0, CARD_W'($urandom));
    offer(CMD_QUERY, ADDR_W'($urandom), 12'd0);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_config(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 20000)),
                      16'd0, 1'b1);
        1: set_config(48'h0, SIZE_W'(HEAP_SIZE_RST), 16'd8, 1'b1);
        2: set_config(48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 8000)),
                      SIZE_W'($urandom_range(513, 30000)), 16'd1, 1'b0);
        3: set_config(ADDR_W'({$urandom, $urandom}), 22'h3F_FFFF, 16'hFFFF, 1'b1);
        4: set_config(ADDR_W'({$urandom, $urandom}), 22'd0, THR_W'($urandom),
                      1'($urandom));
        5: set_config(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 4000)),
                      THR_W'($urandom_range(0, 3)), 1'b1);
        6: set_config(48'hFFFF_FFFF_FFFF, 22'd1, 16'd0, 1'b1);
        default: set_config(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 60000)),
                            THR_W'($urandom_range(0, 2)), 1'b1);
      endcase
      slow = (p == 1 || p == 3) ? 4 : 100;
      if (p == 0) hold_at = cmds_taken + 120;
      for (i = 0; i < 200; i++) begin
        if (i % 40 == 0) begin
          send_idling = (p != 7) && ($urandom_range(0, 3) != 0);
          take_idling = (p != 7) && ($urandom_range(0, 3) != 0);
        end
        it = random_cmd(slow);
        offer(it.command, it.address, it.card_index);
      end
    end

    do @(negedge clk); while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (64) @(posedge clk);

    $display("card table run: %0d commands taken, %0d results checked, %0d register settings",
             cmds_taken, results_seen, settings_used);
    $display("covered all commands, hot cards and promotion, wrapped ranges, empty heap, %0d faults",
             faults);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
